FILE: design/rrht_pkg.sv
// Shared constants and types for the rounded rectangle hit test.
`default_nettype none

package rrht_pkg;

  // Clock edges from an accepted request to the edge that takes its result
  localparam int LATENCY = 10;

  // Configuration register indexes
  typedef enum logic [2:0] {
    CFG_LEFT   = 3'd0,
    CFG_TOP    = 3'd1,
    CFG_WIDTH  = 3'd2,
    CFG_HEIGHT = 3'd3,
    CFG_RAD_X  = 3'd4,
    CFG_RAD_Y  = 3'd5,
    CFG_ZOOM   = 3'd6,
    CFG_TOL    = 3'd7
  } cfg_idx_e;

  // Zoom after reset: 1.0 in Q4.8
  localparam logic [11:0] ZOOM_RESET = 12'd256;

  // Coordinates in 1/8192 pixel
  typedef logic signed [31:0] coord_t;
  // Scaled radius or corner distance, below 2^27
  typedef logic [26:0]        dist_t;
  // Product of two distances
  typedef logic [53:0]        prod_t;
  // Square of a product
  typedef logic [107:0]       sq_t;

endpackage

`default_nettype wire

FILE: design/rounded_rect_hit_test.sv
// Rounded rectangle hit test: a pipeline of ten register stages.
//
//  channel  | ports                                   | handshake
//  ---------+-----------------------------------------+-------------------------------
//  request  | point_x_i, point_y_i                    | taken when start && !busy
//  result   | inside_res_o                            | result_valid_o, one cycle
//  config   | cfg_idx_i, cfg_wdata_i                  | written when cfg_we_i
//
// One request is taken every cycle; busy stays low. Each result is formed by
// the chain of multiplier stages that form and square the corner products,
// with no multiplier wider than 27 x 27.
// Reset clears the valid bits and restores the register defaults; the
// receiver cannot stall, so nothing holds back the pipeline.
`default_nettype none

module rounded_rect_hit_test (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic signed [15:0] point_x_i,
  input  logic signed [15:0] point_y_i,
  output logic               result_valid_o,
  output logic               inside_res_o,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_idx_i,
  input  logic [15:0]        cfg_wdata_i
);
  import rrht_pkg::*;

  // Configuration registers
  logic signed [15:0] left_q, top_q;
  logic [14:0]        bw_q, bh_q, crx_q, cry_q;
  logic [11:0]        zoom_q;
  logic [7:0]         tol_q;

  // Valid bits, one per stage
  logic [LATENCY-1:0] vld_q, vld_d;

  // Stage 1: captured point
  logic signed [15:0] s1_px_q, s1_py_q;

  // Stage 2: scaled geometry
  logic signed [15:0] s2_px_q, s2_py_q;
  coord_t             s2_x0_q, s2_y0_q, s2_x0_d, s2_y0_d;
  logic [27:0]        s2_w_q, s2_h_q;
  dist_t              s2_rx_q, s2_ry_q, s2_rx_d, s2_ry_d;
  logic               s2_zero_q;
  logic signed [28:0] x0_prod, y0_prod;
  logic [26:0]        w_prod, h_prod;
  logic [15:0]        rx_lim, ry_lim;

  // Stage 3: box bounds
  coord_t s3_px_q, s3_py_q;
  coord_t s3_ox0_q, s3_ox1_q, s3_oy0_q, s3_oy1_q;
  coord_t s3_ixl_q, s3_ixh_q, s3_iyl_q, s3_iyh_q;
  coord_t s3_ix0_q, s3_ix1_q, s3_iy0_q, s3_iy1_q;
  dist_t  s3_rx_q, s3_ry_q;
  logic   s3_zero_q;
  coord_t px_full, py_full, e_slack, w_full, h_full, rx_full, ry_full;

  // Stage 4: early decision and corner distances
  logic   s4_dec_q, s4_res_q, s4_dec_d, s4_res_d;
  dist_t  s4_dx_q, s4_dy_q, s4_rx_q, s4_ry_q;
  logic   outer_miss, inner_hit, rad_zero;
  coord_t dx_full, dy_full;

  // Stage 5: cross products
  logic  s5_dec_q, s5_res_q;
  prod_t s5_a_q, s5_b_q, s5_c_q;

  // Stage 6: partial products of the squares
  logic  s6_dec_q, s6_res_q;
  prod_t s6_ahh_q, s6_ahl_q, s6_all_q;
  prod_t s6_bhh_q, s6_bhl_q, s6_bll_q;
  prod_t s6_chh_q, s6_chl_q, s6_cll_q;

  // Stage 7: squares
  logic s7_dec_q, s7_res_q;
  sq_t  s7_a2_q, s7_b2_q, s7_c2_q;

  // Stage 8: margin and tolerance partials
  logic               s8_dec_q, s8_res_q;
  logic signed [109:0] s8_d_q;
  logic [34:0]        s8_p0_q, s8_p1_q, s8_p2_q, s8_p3_q;

  // Stage 9: tolerance term
  logic                s9_dec_q, s9_res_q;
  logic signed [109:0] s9_d_q;
  logic [115:0]        s9_tc2_q;

  // Output stage
  logic                out_inside_q, out_inside_d;
  logic signed [117:0] cmp_lhs, cmp_rhs;
  logic                ell_hit;

  assign busy = 1'b0;

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      left_q <= '0;
      top_q  <= '0;
      bw_q   <= '0;
      bh_q   <= '0;
      crx_q  <= '0;
      cry_q  <= '0;
      zoom_q <= ZOOM_RESET;
      tol_q  <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_idx_i))
        CFG_LEFT:   left_q <= cfg_wdata_i;
        CFG_TOP:    top_q  <= cfg_wdata_i;
        CFG_WIDTH:  bw_q   <= cfg_wdata_i[14:0];
        CFG_HEIGHT: bh_q   <= cfg_wdata_i[14:0];
        CFG_RAD_X:  crx_q  <= cfg_wdata_i[14:0];
        CFG_RAD_Y:  cry_q  <= cfg_wdata_i[14:0];
        CFG_ZOOM:   zoom_q <= cfg_wdata_i[11:0];
        CFG_TOL:    tol_q  <= cfg_wdata_i[7:0];
        default:    ;
      endcase
    end
  end

  // Advance valid bits
  assign vld_d = {vld_q[LATENCY-2:0], start & ~busy};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q        <= '0;
      out_inside_q <= 1'b0;
    end else begin
      vld_q        <= vld_d;
      out_inside_q <= out_inside_d;
    end
  end

  // Scale geometry by zoom; clamp each radius to half the size
  always_comb begin
    x0_prod = left_q * $signed({1'b0, zoom_q});
    y0_prod = top_q * $signed({1'b0, zoom_q});
    w_prod  = bw_q * zoom_q;
    h_prod  = bh_q * zoom_q;
    rx_lim  = ({crx_q, 1'b0} > {1'b0, bw_q}) ? {1'b0, bw_q} : {crx_q, 1'b0};
    ry_lim  = ({cry_q, 1'b0} > {1'b0, bh_q}) ? {1'b0, bh_q} : {cry_q, 1'b0};
    s2_x0_d = {{2{x0_prod[28]}}, x0_prod, 1'b0};
    s2_y0_d = {{2{y0_prod[28]}}, y0_prod, 1'b0};
    s2_rx_d = rx_lim[14:0] * zoom_q;
    s2_ry_d = ry_lim[14:0] * zoom_q;
  end

  // Widen the point, sizes and radii to full coordinates and form the slack
  always_comb begin
    px_full = {{3{s2_px_q[15]}}, s2_px_q, 13'b0};
    py_full = {{3{s2_py_q[15]}}, s2_py_q, 13'b0};
    e_slack = {19'b0, tol_q, 5'b0};
    w_full  = {4'b0, s2_w_q};
    h_full  = {4'b0, s2_h_q};
    rx_full = {5'b0, s2_rx_q};
    ry_full = {5'b0, s2_ry_q};
  end

  // Test the boxes and measure from the nearest corner centre
  always_comb begin
    outer_miss = (s3_px_q < s3_ox0_q) || (s3_px_q > s3_ox1_q) ||
                 (s3_py_q < s3_oy0_q) || (s3_py_q > s3_oy1_q);
    inner_hit  = (s3_px_q >= s3_ixl_q) && (s3_px_q <= s3_ixh_q) &&
                 (s3_py_q >= s3_iyl_q) && (s3_py_q <= s3_iyh_q);
    rad_zero   = (s3_rx_q == '0) || (s3_ry_q == '0);
    s4_dec_d   = s3_zero_q | outer_miss | inner_hit | rad_zero;
    s4_res_d   = ~s3_zero_q & ~outer_miss & inner_hit;
    if (s3_px_q < s3_ix0_q) begin
      dx_full = s3_ix0_q - s3_px_q;
    end else if (s3_px_q > s3_ix1_q) begin
      dx_full = s3_px_q - s3_ix1_q;
    end else begin
      dx_full = '0;
    end
    if (s3_py_q < s3_iy0_q) begin
      dy_full = s3_iy0_q - s3_py_q;
    end else if (s3_py_q > s3_iy1_q) begin
      dy_full = s3_py_q - s3_iy1_q;
    end else begin
      dy_full = '0;
    end
  end

  // Compare the ellipse margin against the tolerance term
  always_comb begin
    cmp_lhs      = {s9_d_q, 8'b0};
    cmp_rhs      = {2'b0, s9_tc2_q};
    ell_hit      = (cmp_lhs <= cmp_rhs);
    out_inside_d = vld_q[LATENCY-2] & (s9_dec_q ? s9_res_q : ell_hit);
  end

  // Pipeline payload
  always_ff @(posedge clk_i) begin
    // capture the request
    s1_px_q <= point_x_i;
    s1_py_q <= point_y_i;

    // scaled geometry
    s2_px_q   <= s1_px_q;
    s2_py_q   <= s1_py_q;
    s2_x0_q   <= s2_x0_d;
    s2_y0_q   <= s2_y0_d;
    s2_w_q    <= {w_prod, 1'b0};
    s2_h_q    <= {h_prod, 1'b0};
    s2_rx_q   <= s2_rx_d;
    s2_ry_q   <= s2_ry_d;
    s2_zero_q <= (bw_q == '0) || (bh_q == '0);

    // bounds
    s3_px_q   <= px_full;
    s3_py_q   <= py_full;
    s3_ox0_q  <= s2_x0_q - e_slack;
    s3_ox1_q  <= s2_x0_q + w_full + e_slack;
    s3_oy0_q  <= s2_y0_q - e_slack;
    s3_oy1_q  <= s2_y0_q + h_full + e_slack;
    s3_ixl_q  <= s2_x0_q + rx_full - e_slack;
    s3_ixh_q  <= s2_x0_q + w_full - rx_full + e_slack;
    s3_iyl_q  <= s2_y0_q + ry_full - e_slack;
    s3_iyh_q  <= s2_y0_q + h_full - ry_full + e_slack;
    s3_ix0_q  <= s2_x0_q + rx_full;
    s3_ix1_q  <= s2_x0_q + w_full - rx_full;
    s3_iy0_q  <= s2_y0_q + ry_full;
    s3_iy1_q  <= s2_y0_q + h_full - ry_full;
    s3_rx_q   <= s2_rx_q;
    s3_ry_q   <= s2_ry_q;
    s3_zero_q <= s2_zero_q;

    // decision and distances; a distance is below 2^27 whenever it matters
    s4_dec_q <= s4_dec_d;
    s4_res_q <= s4_res_d;
    s4_dx_q  <= dx_full[26:0];
    s4_dy_q  <= dy_full[26:0];
    s4_rx_q  <= s3_rx_q;
    s4_ry_q  <= s3_ry_q;

    // cross products dx*ry, dy*rx, rx*ry
    s5_dec_q <= s4_dec_q;
    s5_res_q <= s4_res_q;
    s5_a_q   <= s4_dx_q * s4_ry_q;
    s5_b_q   <= s4_dy_q * s4_rx_q;
    s5_c_q   <= s4_rx_q * s4_ry_q;

    // partial products of the squares, split at bit 27
    s6_dec_q <= s5_dec_q;
    s6_res_q <= s5_res_q;
    s6_ahh_q <= s5_a_q[53:27] * s5_a_q[53:27];
    s6_ahl_q <= s5_a_q[53:27] * s5_a_q[26:0];
    s6_all_q <= s5_a_q[26:0] * s5_a_q[26:0];
    s6_bhh_q <= s5_b_q[53:27] * s5_b_q[53:27];
    s6_bhl_q <= s5_b_q[53:27] * s5_b_q[26:0];
    s6_bll_q <= s5_b_q[26:0] * s5_b_q[26:0];
    s6_chh_q <= s5_c_q[53:27] * s5_c_q[53:27];
    s6_chl_q <= s5_c_q[53:27] * s5_c_q[26:0];
    s6_cll_q <= s5_c_q[26:0] * s5_c_q[26:0];

    // squares
    s7_dec_q <= s6_dec_q;
    s7_res_q <= s6_res_q;
    s7_a2_q  <= {s6_ahh_q, 54'b0} + {26'b0, s6_ahl_q, 28'b0} + {54'b0, s6_all_q};
    s7_b2_q  <= {s6_bhh_q, 54'b0} + {26'b0, s6_bhl_q, 28'b0} + {54'b0, s6_bll_q};
    s7_c2_q  <= {s6_chh_q, 54'b0} + {26'b0, s6_chl_q, 28'b0} + {54'b0, s6_cll_q};

    // margin over the bound and tolerance partials
    s8_dec_q <= s7_dec_q;
    s8_res_q <= s7_res_q;
    s8_d_q   <= $signed({2'b0, s7_a2_q}) + $signed({2'b0, s7_b2_q})
              - $signed({2'b0, s7_c2_q});
    s8_p0_q  <= s7_c2_q[26:0] * tol_q;
    s8_p1_q  <= s7_c2_q[53:27] * tol_q;
    s8_p2_q  <= s7_c2_q[80:54] * tol_q;
    s8_p3_q  <= s7_c2_q[107:81] * tol_q;

    // tolerance term
    s9_dec_q <= s8_dec_q;
    s9_res_q <= s8_res_q;
    s9_d_q   <= s8_d_q;
    s9_tc2_q <= {81'b0, s8_p0_q} + {54'b0, s8_p1_q, 27'b0}
              + {27'b0, s8_p2_q, 54'b0} + {s8_p3_q, 81'b0};
  end

  assign result_valid_o = vld_q[LATENCY-1];
  assign inside_res_o   = out_inside_q;

endmodule

`default_nettype wire

FILE: design/rrht_checker.sv
// Port checker for the rounded rectangle hit test, bound to the top level.
`default_nettype none

module rrht_checker (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic start,
  input  logic busy,
  input  logic result_valid_o,
  input  logic inside_res_o
);
  import rrht_pkg::*;

  // Every request yields a result after the pipeline latency
  a_req_to_res: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |-> ##LATENCY result_valid_o)
    else $error("request without its result");

  // No result without a request that latency before
  a_res_from_req: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start && !busy, LATENCY))
    else $error("result without a request");

  // Hit flag stays low between results
  a_res_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !result_valid_o |-> !inside_res_o)
    else $error("hit flag raised without a result strobe");

endmodule

bind rounded_rect_hit_test rrht_checker u_rrht_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start          (start),
  .busy           (busy),
  .result_valid_o (result_valid_o),
  .inside_res_o   (inside_res_o)
);

`default_nettype wire
